// File: design/tssp_pkg.sv
// Package for the track skew sequence picker: widths, table geometry and
// shared types. Used by every module of the block except tssp_ram.
package tssp_pkg;

  localparam int MaxSeqs = 16;
  localparam int IdxW = 4;
  localparam int PosW = 18;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] lim;
    logic [15:0] len;
    logic [15:0] chunk;
    logic [15:0] cap;
  } seq_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // write the entry from the input item
    logic begin_step; // latch item, restart, start capacity fetch
    logic reduce;     // start modulo of the position
    logic eval;       // evaluate entry at cur index (division start)
    logic compare;    // fold result of the division
    logic finish;     // start rotations division / final result
    logic commit;     // update position and counters, present result
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic last_entry;
  } dp_sts_t;

  localparam logic [1:0] RegAbs = 2'd0;
  localparam logic [1:0] RegHead = 2'd1;
  localparam logic [1:0] RegCyl = 2'd2;
  localparam logic [1:0] RegCount = 2'd3;

endpackage

// File: design/tssp_ram.sv
// Generic single-port-write RAM with registered read.
// No dependencies.
module tssp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/tssp_div.sv
// Restoring divider, one quotient bit per cycle, 18-bit dividend, 16-bit divisor.
// Depends on tssp_pkg.
module tssp_div
  import tssp_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [PosW-1:0] dividend,
  input  logic [15:0]     divisor,
  output logic            busy,
  output logic [PosW-1:0] quot,
  output logic [15:0]     rem
);
  logic [PosW-1:0] q_r, q_nxt;
  logic [16:0] r_r, r_nxt;
  logic [15:0] d_r, d_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [17:0] trial;

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    d_nxt = d_r;
    cnt_nxt = cnt_r;
    trial = {r_r, q_r[PosW-1]} - {2'b00, d_r};
    if (start) begin
      q_nxt = dividend;
      r_nxt = '0;
      d_nxt = divisor;
      cnt_nxt = 5'(PosW);
    end else if (cnt_r != 5'd0) begin
      if (!trial[17]) begin
        r_nxt = trial[16:0];
        q_nxt = {q_r[PosW-2:0], 1'b1};
      end else begin
        r_nxt = {r_r[15:0], q_r[PosW-1]};
        q_nxt = {q_r[PosW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign busy = start || (cnt_r != 5'd0);
  assign quot = q_r;
  assign rem = r_r[15:0];
endmodule

// File: design/tssp_datapath.sv
// Datapath of the sequence picker: tables, position, divider, best tracking.
// Depends on tssp_pkg, tssp_ram and tssp_div.
module tssp_datapath
  import tssp_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  dp_cmd_t         cmd,
  output dp_sts_t         sts,
  input  logic            raddr_best,
  input  logic            raddr_norm0,
  input  logic            in_table,
  input  logic [IdxW-1:0] in_index,
  input  seq_entry_t      in_entry,
  input  logic            in_restart,
  input  logic            in_last_head,
  input  logic [15:0]     abs_skew,
  input  logic [15:0]     trk_skew,
  input  logic [15:0]     cyl_skew,
  input  logic [4:0]      seq_count,
  output logic [IdxW-1:0] res_index,
  output logic [15:0]     res_skew,
  output logic [PosW-1:0] res_end,
  output logic [15:0]     res_rot,
  output logic            res_big
);
  localparam int AW = $clog2(2 * MaxSeqs);
  localparam int EW = $bits(seq_entry_t);

  logic [AW-1:0] raddr;
  seq_entry_t rd, rd_n;
  logic [EW-1:0] rd_raw;

  logic tbl_r, tbl_nxt, lh_r, lh_nxt;
  logic [PosW-1:0] pos_r, pos_nxt, p_r, p_nxt, best_r, best_nxt;
  logic [15:0] rot_r, rot_nxt, bsk_r, bsk_nxt, cap0_r, cap0_nxt, ncap0_r, ncap0_nxt;
  logic [IdxW-1:0] bi_r, bi_nxt, ci_r, ci_nxt;
  logic [4:0] lim_n;
  logic div_start, div_busy;
  logic [PosW-1:0] dvd, quot;
  logic [15:0] dvs, rem;
  seq_entry_t e_r, e_nxt;
  logic [1:0] ph_r, ph_nxt; // 0 none,1 reduce,2 entry,3 rotations

  tssp_ram #(.Width(EW), .Depth(2 * MaxSeqs)) u_tab (
    .clk(clk), .we(cmd.load), .waddr({in_table, in_index}), .wdata(in_entry),
    .raddr(raddr), .rdata(rd_raw));
  assign rd = seq_entry_t'(rd_raw);

  tssp_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd), .divisor(dvs),
    .busy(div_busy), .quot(quot), .rem(rem));

  always_comb begin
    lim_n = (seq_count == 5'd0) ? 5'd1 : ((seq_count > 5'(MaxSeqs)) ? 5'(MaxSeqs) : seq_count);
    sts.div_busy = div_busy;
    sts.last_entry = ({1'b0, ci_r} + 5'd1) >= lim_n;
  end

  // Read address: controller steps present it ahead so the registered read data is ready when used.
  // The size check reads entry 0 and the chosen entry of the normal table.
  always_comb begin
    raddr = {tbl_r, ci_r};
    if (raddr_norm0) raddr = {1'b0, {IdxW{1'b0}}};
    if (raddr_best) raddr = {1'b0, bi_r};
    if (cmd.begin_step) raddr = {in_table, {IdxW{1'b0}}};
  end

  logic [16:0] ch_eff;
  logic [PosW-1:0] kq;
  logic [PosW+15:0] k_ch;
  logic [PosW+16:0] bnd;
  logic [PosW+1:0] nxt_sum;
  logic [PosW:0] rot_sum;
  logic [31:0] chk;
  logic [PosW:0] cand;
  logic [15:0] csk;
  logic [15:0] nch;

  always_comb begin
    tbl_nxt = tbl_r; lh_nxt = lh_r; pos_nxt = pos_r; p_nxt = p_r;
    best_nxt = best_r; rot_nxt = rot_r; bsk_nxt = bsk_r; bi_nxt = bi_r;
    ci_nxt = ci_r; cap0_nxt = cap0_r; ncap0_nxt = ncap0_r; e_nxt = e_r;
    ph_nxt = ph_r;
    div_start = 1'b0; dvd = '0; dvs = 16'd1;
    ch_eff = (e_r.chunk == 16'd0) ? 17'd1 : {1'b0, e_r.chunk};
    // The divider holds floor((p - start - 1) / chunk), so the ceiling is one more.
    kq = (p_r > PosW'(e_r.start)) ? quot + PosW'(1) : '0;
    k_ch = (PosW+16)'(kq) * (PosW+16)'(ch_eff[15:0]);
    bnd = (PosW+17)'(e_r.start) + (PosW+17)'(k_ch);
    cand = '0; csk = '0;
    rot_sum = '0; nxt_sum = '0;
    rd_n = rd;
    nch = (rd_n.chunk == 16'd0) ? 16'd1 : rd_n.chunk;
    if (cmd.begin_step) begin
      tbl_nxt = in_table; lh_nxt = in_last_head; ci_nxt = '0;
      if (in_restart) begin
        pos_nxt = PosW'(abs_skew); rot_nxt = '0;
      end
    end
    if (cmd.reduce) begin
      // rd is entry 0 of the selected table; normal entry 0 fetched later.
      cap0_nxt = rd_n.cap;
      e_nxt = rd_n;
      if (rd_n.cap != 16'd0) begin
        div_start = 1'b1; dvd = pos_r; dvs = rd_n.cap; ph_nxt = 2'd1;
      end else begin
        p_nxt = pos_r; ph_nxt = 2'd0;
      end
    end
    if (ph_r == 2'd1 && !div_busy) begin
      p_nxt = PosW'(rem); ph_nxt = 2'd0;
    end
    if (cmd.eval) begin
      e_nxt = rd_n;
      ph_nxt = 2'd2;
      div_start = 1'b1;
      if (p_r > PosW'(rd_n.start)) begin
        dvd = p_r - PosW'(rd_n.start) - PosW'(1);
        dvs = (rd_n.chunk == 16'd0) ? 16'd1 : rd_n.chunk;
      end else begin
        dvd = '0; dvs = 16'd1;
      end
    end
    if (cmd.compare) begin
      if (p_r < PosW'(e_r.start)) begin
        cand = (PosW+1)'(e_r.start) + (PosW+1)'(e_r.len); csk = '0;
      end else if (bnd >= (PosW+17)'(e_r.lim)) begin
        cand = (PosW+1)'(e_r.start) + (PosW+1)'(e_r.len) + (PosW+1)'(e_r.cap); csk = '0;
      end else begin
        // Below the end limit the boundary and the chunk count fit 16 bits.
        cand = bnd[PosW:0] + (PosW+1)'(e_r.len); csk = kq[15:0];
      end
      if (ci_r == '0 || cand < (PosW+1)'(best_r)) begin
        best_nxt = PosW'(cand); bsk_nxt = csk; bi_nxt = ci_r;
      end
      ci_nxt = ci_r + IdxW'(1);
    end
    if (cmd.finish) begin
      div_start = 1'b1; dvd = best_r;
      dvs = (cap0_r == 16'd0) ? 16'd1 : cap0_r;
      ph_nxt = 2'd3;
    end
    if (cmd.commit) begin
      // rd holds normal entry bi and ncap0_r normal entry 0 capacity.
      rot_sum = (PosW+1)'(rot_r) + ((cap0_r == 16'd0) ? '0 : (PosW+1)'(quot));
      rot_nxt = (rot_sum > (PosW+1)'(16'hFFFF)) ? 16'hFFFF : rot_sum[15:0];
      nxt_sum = (PosW+2)'(best_r) + (PosW+2)'(trk_skew);
      if (lh_r) begin
        if (cyl_skew >= trk_skew) nxt_sum = nxt_sum + (PosW+2)'(cyl_skew - trk_skew);
        else if (nxt_sum >= (PosW+2)'(trk_skew - cyl_skew))
          nxt_sum = nxt_sum - (PosW+2)'(trk_skew - cyl_skew);
        else nxt_sum = '0;
      end
      pos_nxt = (nxt_sum > (PosW+2)'(18'h3FFFF)) ? 18'h3FFFF : PosW'(nxt_sum);
      ph_nxt = 2'd0;
    end
    chk = bsk_r * nch;
    if (cmd.finish) ncap0_nxt = rd_n.cap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; rot_r <= '0; ph_r <= '0;
    end else begin
      pos_r <= pos_nxt; rot_r <= rot_nxt; ph_r <= ph_nxt;
    end
    tbl_r <= tbl_nxt; lh_r <= lh_nxt; p_r <= p_nxt; best_r <= best_nxt;
    bsk_r <= bsk_nxt; bi_r <= bi_nxt; ci_r <= ci_nxt; cap0_r <= cap0_nxt;
    ncap0_r <= ncap0_nxt; e_r <= e_nxt;
  end

  // Rotations and the size flag are taken in the commit cycle.
  assign res_index = bi_r;
  assign res_skew = bsk_r;
  assign res_end = best_r;
  assign res_rot = rot_nxt;
  assign res_big = chk > {16'd0, ncap0_r};
endmodule

// File: design/tssp_ctrl.sv
// Controller of the sequence picker: sequences load, reduction, entry walk
// and result handshake. Depends on tssp_pkg.
module tssp_ctrl
  import tssp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_fire,
  input  logic    in_mode,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output logic    res_load,
  output logic    raddr_best,
  output logic    raddr_norm0,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_RED = 10'b0000000010, S_REDW = 10'b0000000100,
    S_RD = 10'b0000001000, S_EVAL = 10'b0000010000, S_DIVW = 10'b0000100000,
    S_CMP = 10'b0001000000, S_FIN = 10'b0010000000, S_FINW = 10'b0100000000,
    S_OUT = 10'b1000000000
  } state_t;
  state_t st_r, st_nxt;
  logic ov_r, ov_nxt;
  logic [1:0] wc_r, wc_nxt;

  always_comb begin
    st_nxt = st_r; ov_nxt = ov_r; wc_nxt = wc_r;
    cmd = '0; res_load = 1'b0; raddr_best = 1'b0; raddr_norm0 = 1'b0;
    in_ready = (st_r == S_IDLE);
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: if (in_fire) begin
        if (!in_mode) cmd.load = 1'b1;
        else begin cmd.begin_step = 1'b1; st_nxt = S_RED; end
      end
      S_RED: begin cmd.reduce = 1'b1; st_nxt = S_REDW; end
      S_REDW: if (!sts.div_busy) st_nxt = S_RD;
      S_RD: st_nxt = S_EVAL;
      S_EVAL: begin cmd.eval = 1'b1; st_nxt = S_DIVW; end
      S_DIVW: if (!sts.div_busy) st_nxt = S_CMP;
      S_CMP: begin
        cmd.compare = 1'b1;
        st_nxt = sts.last_entry ? S_FIN : S_RD;
        raddr_norm0 = sts.last_entry;
      end
      S_FIN: begin raddr_norm0 = 1'b1; cmd.finish = 1'b1; st_nxt = S_FINW; wc_nxt = 2'd0; end
      S_FINW: begin
        raddr_best = 1'b1;
        if (wc_r != 2'd2) wc_nxt = wc_r + 2'd1;
        if (!sts.div_busy && wc_r == 2'd2) st_nxt = S_OUT;
      end
      S_OUT: begin
        raddr_best = 1'b1;
        if (!ov_r || out_ready) begin
          cmd.commit = 1'b1; res_load = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0; wc_r <= '0;
    end else begin
      st_r <= st_nxt; wc_r <= wc_nxt;
      ov_r <= res_load ? 1'b1 : ov_nxt;
    end
  end
  assign out_valid = ov_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> st_r == S_IDLE) else $error("ready outside idle");
  a_load_one: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> out_valid) else $error("result lost");
  a_no_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval |-> !$past(sts.div_busy)) else $error("divider overlap");
endmodule

// File: design/track_skew_sequence_picker_top.sv
// Top level of the track skew sequence picker: stream ports, APB registers,
// controller and datapath. Depends on tssp_pkg, tssp_ctrl, tssp_datapath.
//
//  channel | direction | payload
//  in_     | slave     | tdata {last_head,restart,capacity,chunk,length,end,start,index,table,mode}
//  out_    | master    | tdata {too_big,rotations,end_position,skew_chunks,chosen_index}
//  cfg_    | APB slave | absolute, head, cylinder skew and sequence count
//
// A step item over N compared entries holds the block until its result is
// registered, and the next item is taken only after that; one shared divider
// of 18 steps, run up to N + 2 times (N + 1 when entry 0 has no capacity), does
// the divisions. Reset is synchronous on rst_n and clears position, rotations
// and the skew registers and sets the sequence count register to 1; the tables
// are undefined until loaded. A result waits in an output register while new
// items are taken; a finished step stalls until that register is free.
module track_skew_sequence_picker_top
  import tssp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // bits: mode[0] table_req[1] entry_index[5:2] seq_start[21:6] seq_end[37:22]
  // seq_length[53:38] seq_chunk[69:54] seq_capacity[85:70] restart[86] last_head[87]
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // bits: chosen_index[3:0] skew_chunks[19:4] end_position[37:20] rotations[53:38]
  // skew_too_big[54], zero filled to 56
  output logic [55:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [15:0] abs_r, head_r, cyl_r;
  logic [4:0] cnt_r;
  logic wr;
  dp_cmd_t cmd;
  dp_sts_t sts;
  seq_entry_t ent;
  logic res_load, rb, rn;
  logic [IdxW-1:0] ri;
  logic [15:0] rs, rr;
  logic [PosW-1:0] re;
  logic rbig;
  logic [54:0] res_r;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abs_r <= '0; head_r <= '0; cyl_r <= '0; cnt_r <= 5'd1;
    end else if (wr && cfg_paddr[1:0] == 2'b00) begin
      case (cfg_paddr[3:2])
        RegAbs: abs_r <= cfg_pwdata[15:0];
        RegHead: head_r <= cfg_pwdata[15:0];
        RegCyl: cyl_r <= cfg_pwdata[15:0];
        RegCount: cnt_r <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (cfg_paddr[3:2])
      RegAbs: cfg_prdata = {16'd0, abs_r};
      RegHead: cfg_prdata = {16'd0, head_r};
      RegCyl: cfg_prdata = {16'd0, cyl_r};
      RegCount: cfg_prdata = {27'd0, cnt_r};
      default: cfg_prdata = '0;
    endcase
  end

  assign ent = '{start: in_tdata[21:6], lim: in_tdata[37:22], len: in_tdata[53:38],
                 chunk: in_tdata[69:54], cap: in_tdata[85:70]};

  tssp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_tvalid && in_tready), .in_mode(in_tdata[0]),
    .in_ready(in_tready), .out_valid(out_tvalid), .out_ready(out_tready),
    .res_load(res_load), .raddr_best(rb), .raddr_norm0(rn), .cmd(cmd), .sts(sts));

  tssp_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_table(in_tdata[1]), .in_index(in_tdata[5:2]), .in_entry(ent),
    .in_restart(in_tdata[86]), .in_last_head(in_tdata[87]),
    .abs_skew(abs_r), .trk_skew(head_r), .cyl_skew(cyl_r), .seq_count(cnt_r),
    .res_index(ri), .res_skew(rs), .res_end(re), .res_rot(rr), .res_big(rbig),
    .raddr_best(rb), .raddr_norm0(rn));

  always_ff @(posedge clk) begin
    if (res_load) res_r <= {rbig, rr, re, rs, ri};
  end
  assign out_tdata = {1'b0, res_r};
endmodule
